FILE: rtl/core/ikht_pkg.sv
// ----------------------------------------------------------------------------
// ikht_pkg
// Shared types and constants of the integer-key hash table with linear probing.
// ----------------------------------------------------------------------------
package ikht_pkg;

	// Default number of slots and the table size register.
	localparam int unsigned SLOTS_DEF   = 256;
	localparam int unsigned TSIZE_W     = 9;
	localparam logic [TSIZE_W-1:0] TSIZE_RESET = 9'd256;

	// Stream payload widths.
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned OUT_USER_W = 3;

	// One table entry: used mark, key and value.
	localparam int unsigned ENTRY_W = 65;

	// Hashing constants: djb2 start, start after a leading minus sign,
	// ASCII zero, and the reciprocal of ten for digit extraction.
	localparam logic [63:0] DJB2_INIT     = 64'd5381;
	localparam logic [63:0] DJB2_NEG_INIT = 64'd177618;
	localparam logic [7:0]  CHAR_ZERO     = 8'd48;
	localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
	localparam int unsigned RECIP10_SHIFT = 35;
	localparam int unsigned MAX_DIGITS    = 10;
	localparam int unsigned DIGIT_W       = 4;
	localparam int unsigned DCNT_W        = 4;
	localparam int unsigned MOD_STEPS     = 32;
	localparam int unsigned MOD_CNT_W     = 5;

	// Request kinds.
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_STORE  = 1'b1;

	// Probe outcomes.
	localparam logic [1:0] OUTCOME_PRESENT = 2'd0;
	localparam logic [1:0] OUTCOME_ABSENT  = 2'd1;
	localparam logic [1:0] OUTCOME_FULL    = 2'd2;

	// Hash unit states.
	typedef enum logic [1:0] {
		H_IDLE,
		H_DIGIT,
		H_HASH,
		H_MOD
	} hash_state_t;

	// Probe sequencer states.
	typedef enum logic [2:0] {
		P_CLEAR,
		P_IDLE,
		P_HASH,
		P_READ,
		P_CHECK,
		P_DONE
	} probe_state_t;

endpackage

FILE: rtl/core/ikht_ram.sv
// ----------------------------------------------------------------------------
// ikht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ikht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/ikht_hasher.sv
// ----------------------------------------------------------------------------
// ikht_hasher
// Turns a signed key into its decimal text, runs djb2 over it and reduces the
// 64-bit hash modulo the table size, giving the home slot of the probe.
// ----------------------------------------------------------------------------
module ikht_hasher #(
	parameter int unsigned SLOTS = ikht_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [31:0]                      key,
	input  logic [$clog2(SLOTS+1)-1:0]       size,
	output logic                             done,
	output logic [$clog2(SLOTS)-1:0]         index
);
	import ikht_pkg::*;

	localparam int unsigned SW = $clog2(SLOTS + 1);
	localparam int unsigned IW = $clog2(SLOTS);

	hash_state_t state_q, state_d;

	logic [31:0]          mag_q;
	logic [DIGIT_W-1:0]   digit_q [MAX_DIGITS];
	logic [DCNT_W-1:0]    n_q;
	logic [63:0]          h_q;
	logic [SW-1:0]        rem_q;
	logic [SW-1:0]        size_q;
	logic [MOD_CNT_W-1:0] mcnt_q;
	logic                 done_q;

	logic [63:0]        prod;
	logic [31:0]        quot;
	logic [DIGIT_W-1:0] digit;
	logic [DIGIT_W-1:0] top_digit;
	logic [SW:0]        r1, r1s, r2, r2s;
	logic               last_mod;

	// Divide the magnitude by ten with a reciprocal multiply.
	assign prod  = mag_q * RECIP10;
	assign quot  = 32'(prod >> RECIP10_SHIFT);
	assign digit = DIGIT_W'(mag_q - ((quot << 3) + (quot << 1)));

	// Most significant digit still to be hashed.
	assign top_digit = digit_q[DCNT_W'(n_q - 1'b1)];

	// Two restoring division steps per cycle.
	always_comb begin
		r1  = {rem_q, h_q[63]};
		r1s = (r1 >= {1'b0, size_q}) ? (r1 - {1'b0, size_q}) : r1;
		r2  = {r1s[SW-1:0], h_q[62]};
		r2s = (r2 >= {1'b0, size_q}) ? (r2 - {1'b0, size_q}) : r2;
	end

	assign last_mod = (mcnt_q == MOD_CNT_W'(MOD_STEPS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE:  if (start) state_d = H_DIGIT;
			H_DIGIT: if (quot == 32'd0) state_d = H_HASH;
			H_HASH:  if (n_q == DCNT_W'(1)) state_d = H_MOD;
			H_MOD:   if (last_mod) state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		done  = done_q;
		index = IW'(rem_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == H_MOD) && last_mod;
		end
	end

	// Datapath: digit extraction, djb2 steps, then the modulo reduction.
	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				if (start) begin
					mag_q  <= key[31] ? (32'd0 - key) : key;
					h_q    <= key[31] ? DJB2_NEG_INIT : DJB2_INIT;
					n_q    <= '0;
					size_q <= size;
				end
			end
			H_DIGIT: begin
				digit_q[n_q] <= digit;
				n_q          <= n_q + 1'b1;
				mag_q        <= quot;
			end
			H_HASH: begin
				h_q    <= (h_q << 5) + h_q + 64'(CHAR_ZERO + 8'(top_digit));
				n_q    <= n_q - 1'b1;
				rem_q  <= '0;
				mcnt_q <= '0;
			end
			H_MOD: begin
				rem_q  <= r2s[SW-1:0];
				h_q    <= h_q << 2;
				mcnt_q <= mcnt_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/int_key_hash_table_linear_probe_core.sv
// ----------------------------------------------------------------------------
// int_key_hash_table_linear_probe_core
// Open-addressing hash map from signed 32-bit keys to 32-bit values.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: tuser holds the request kind (lookup or
// store) and the overwrite flag, tdata the key and the value to store. Each
// request gives exactly one result transfer on the m_ stream carrying the ok
// flag, the probe outcome, the value read and the slot where the probe ended.
// The cfg channel writes the table size (1 to 256, zero acts as 1); write it
// only while no request is in flight.
// A request is accepted, its D decimal digits are extracted and then hashed
// one at a time, and the 64-bit modulo unit reduces the hash two bits a cycle.
// Then P slots are probed: each probe is a table RAM read followed by a
// compare. A full lap ends with a lap check instead of a read. The result
// becomes valid in the same cycle as the next request can be taken.
// Requests are handled one at a time; a new one is taken while the previous
// result still waits in the output register.
// After reset the table is cleared by a pass that writes every slot, during
// which s_tready stays low; cfg writes are taken throughout.
// When the receiver stalls, the finished result is held and at most one more
// request is worked on before the block stops accepting.
// ----------------------------------------------------------------------------
module int_key_hash_table_linear_probe_core #(
	parameter int unsigned SLOTS = ikht_pkg::SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Request stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ikht_pkg::IN_DATA_W-1:0]       s_tdata,  // key[31:0], write_value[63:32]
	input  logic [ikht_pkg::IN_USER_W-1:0]       s_tuser,  // req_type[0], overwrite[1]
	// Result stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ikht_pkg::OUT_DATA_W-1:0]      m_tdata,  // read_value[31:0], slot[39:32]
	output logic [ikht_pkg::OUT_USER_W-1:0]      m_tuser,  // ok[0], outcome[2:1]
	// Table size register.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ikht_pkg::TSIZE_W-1:0]         cfg_data
);
	import ikht_pkg::*;

	localparam int unsigned SW = $clog2(SLOTS + 1);
	localparam int unsigned IW = $clog2(SLOTS);

	probe_state_t state_q, state_d;

	logic [TSIZE_W-1:0] tsize_q;
	logic [SW-1:0]      size_w;
	logic [SW-1:0]      size_q;

	logic               req_q;
	logic               ovw_q;
	logic [31:0]        key_q;
	logic [31:0]        wval_q;
	logic [IW-1:0]      idx_q;
	logic [SW-1:0]      cnt_q;
	logic [IW-1:0]      clr_q;

	logic               ok_q;
	logic [1:0]         outcome_q;
	logic [31:0]        rval_q;
	logic [7:0]         slot_q;

	logic               m_valid_q;
	logic               m_ok_q;
	logic [1:0]         m_outcome_q;
	logic [31:0]        m_rval_q;
	logic [7:0]         m_slot_q;

	logic               h_start;
	logic               h_done;
	logic [IW-1:0]      h_index;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	logic               e_used;
	logic [31:0]        e_key;
	logic [31:0]        e_val;
	logic               key_hit;
	logic               out_free;
	logic               lap_done;

	// Size in use: zero counts as one, larger than the table saturates.
	always_comb begin
		if (tsize_q == '0) begin
			size_w = SW'(1);
		end else if (32'(tsize_q) > 32'(SLOTS)) begin
			size_w = SW'(SLOTS);
		end else begin
			size_w = SW'(tsize_q);
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TSIZE_RESET;
		end else if (cfg_valid) begin
			tsize_q <= cfg_data;
		end
	end

	// Home slot computation.
	ikht_hasher #(
		.SLOTS (SLOTS)
	) u_hasher (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (h_start),
		.key    (s_tdata[31:0]),
		.size   (size_w),
		.done   (h_done),
		.index  (h_index)
	);

	// Table entries: used mark, key, value.
	ikht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign e_used   = ram_rdata[ENTRY_W-1];
	assign e_key    = ram_rdata[63:32];
	assign e_val    = ram_rdata[31:0];
	assign key_hit  = e_used && (e_key == key_q);
	assign out_free = !m_valid_q || m_tready;
	assign lap_done = (cnt_q == size_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			P_CLEAR: if (clr_q == IW'(SLOTS - 1)) state_d = P_IDLE;
			P_IDLE:  if (s_tvalid) state_d = P_HASH;
			P_HASH:  if (h_done) state_d = P_READ;
			P_READ:  state_d = lap_done ? P_DONE : P_CHECK;
			P_CHECK: state_d = (!e_used || key_hit) ? P_DONE : P_READ;
			P_DONE:  if (out_free) state_d = P_IDLE;
			default: state_d = P_IDLE;
		endcase
	end

	// State outputs: handshake, hash start and table port control.
	always_comb begin
		s_tready  = 1'b0;
		h_start   = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {1'b1, key_q, wval_q};
		unique case (state_q)
			P_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			P_IDLE: begin
				s_tready = 1'b1;
				h_start  = s_tvalid;
			end
			P_READ: begin
				ram_re = !lap_done;
			end
			P_CHECK: begin
				// Insert on an empty slot, or replace the value when asked to.
				ram_we = (req_q == REQ_STORE) && (!e_used || (key_hit && ovw_q));
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= P_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == P_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == P_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, probe walk and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				if (s_tvalid) begin
					req_q  <= s_tuser[0];
					ovw_q  <= s_tuser[1];
					key_q  <= s_tdata[31:0];
					wval_q <= s_tdata[63:32];
					size_q <= size_w;
				end
			end
			P_HASH: begin
				idx_q <= h_index;
				cnt_q <= '0;
			end
			P_READ: begin
				if (lap_done) begin
					ok_q      <= 1'b0;
					outcome_q <= OUTCOME_FULL;
					rval_q    <= '0;
					slot_q    <= '0;
				end
			end
			P_CHECK: begin
				slot_q <= 8'(idx_q);
				if (!e_used) begin
					ok_q      <= (req_q == REQ_STORE);
					outcome_q <= OUTCOME_ABSENT;
					rval_q    <= '0;
				end else if (key_hit) begin
					ok_q      <= (req_q == REQ_STORE) ? ovw_q : 1'b1;
					outcome_q <= OUTCOME_PRESENT;
					rval_q    <= (req_q == REQ_STORE) ? 32'd0 : e_val;
				end else begin
					// Step to the next slot, wrapping at the size in use.
					idx_q <= ((SW'(idx_q) + SW'(1)) == size_q) ? '0 : IW'(idx_q + 1'b1);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			P_DONE: begin
				if (out_free) begin
					m_ok_q      <= ok_q;
					m_outcome_q <= outcome_q;
					m_rval_q    <= rval_q;
					m_slot_q    <= slot_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_slot_q, m_rval_q};
	assign m_tuser  = {m_outcome_q, m_ok_q};

	// No request is taken while the table is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == P_CLEAR) |-> !s_tready)
		else $error("request accepted during table clear");

	// The hash unit only finishes while the sequencer waits for it.
	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		h_done |-> (state_q == P_HASH))
		else $error("hash result outside the hash wait");

	// The probe never passes a full lap and stays inside the table in use.
	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == P_READ) |-> ((cnt_q <= size_q) && (SW'(idx_q) < size_q)))
		else $error("probe left the table in use");

	// A finished result waits for the output register to be free.
	a_result_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == P_DONE && m_tvalid && !m_tready) |=> (state_q == P_DONE))
		else $error("result dropped while the receiver stalls");

endmodule
